// ===== design/dfa_pkg.sv =====
package dfa_pkg;

   localparam int STATE_W = 6;
   localparam int SYM_W = 8;
   localparam int KIND_W = 3;
   localparam int ACT_W = 2;
   localparam int STATUS_W = 3;
   localparam int MASK_W = 64;
   localparam int CSR_IDX_W = 1;
   localparam int CSR_DATA_W = 64;

   localparam int NUM_STATES_DEF = 64;
   localparam int LINKS_PER_STATE_DEF = 16;

   localparam logic [ACT_W-1:0] ACT_FEED = 2'd0;
   localparam logic [ACT_W-1:0] ACT_ADD = 2'd1;
   localparam logic [ACT_W-1:0] ACT_RESTART = 2'd2;

   localparam logic [KIND_W-1:0] KIND_EXACT = 3'd0;
   localparam logic [KIND_W-1:0] KIND_DIGIT = 3'd1;
   localparam logic [KIND_W-1:0] KIND_ALPHA = 3'd2;
   localparam logic [KIND_W-1:0] KIND_BLANK = 3'd3;
   localparam logic [KIND_W-1:0] KIND_ANY = 3'd4;

   localparam logic [STATUS_W-1:0] ST_NOT_DONE = 3'd0;
   localparam logic [STATUS_W-1:0] ST_ACCEPTED = 3'd1;
   localparam logic [STATUS_W-1:0] ST_REJECTED = 3'd2;
   localparam logic [STATUS_W-1:0] ST_ADDED = 3'd3;
   localparam logic [STATUS_W-1:0] ST_FULL = 3'd4;
   localparam logic [STATUS_W-1:0] ST_RESTARTED = 3'd5;

   localparam logic [CSR_IDX_W-1:0] CSR_START = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_MASK = 1'd1;

   typedef struct packed {
      logic [KIND_W-1:0]  kind;
      logic [SYM_W-1:0]   label;
      logic [STATE_W-1:0] target;
   } link_entry_type;

   typedef struct packed {
      logic load_item;
      logic read_count;
      logic count_step;
      logic scan_step;
      logic scan_final;
      logic rsp_load;
   } dfa_cmd_type;

   typedef struct packed {
      logic [ACT_W-1:0] action;
      logic             feed_go;
      logic             exact_hit;
      logic             scan_last;
   } dfa_stat_type;

   function automatic logic class_match(input logic [KIND_W-1:0] kind,
                                        input logic [SYM_W-1:0] b);
      logic dig;
      logic alp;
      logic blk;
      dig = (b >= 8'd48) && (b <= 8'd57);
      alp = ((b >= 8'd65) && (b <= 8'd90)) || ((b >= 8'd97) && (b <= 8'd122));
      blk = ((b >= 8'd9) && (b <= 8'd13)) || (b == 8'd32);
      return ((kind == KIND_DIGIT) && dig) || ((kind == KIND_ALPHA) && alp) ||
             ((kind == KIND_BLANK) && blk);
   endfunction

endpackage

// ===== design/dfa_req_if.sv =====
interface dfa_req_if;
   logic                         valid;
   logic                         ready;
   logic [dfa_pkg::ACT_W-1:0]    action;
   logic [dfa_pkg::SYM_W-1:0]    symbol;
   logic [dfa_pkg::KIND_W-1:0]   link_kind;
   logic [dfa_pkg::STATE_W-1:0]  from_state;
   logic [dfa_pkg::STATE_W-1:0]  to_state;

   modport source(output valid, action, symbol, link_kind, from_state, to_state,
                  input ready);
   modport sink(input valid, action, symbol, link_kind, from_state, to_state,
                output ready);
endinterface

// ===== design/dfa_rsp_if.sv =====
interface dfa_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [dfa_pkg::STATUS_W-1:0]  status;
   logic [dfa_pkg::STATE_W-1:0]   current_state;

   modport source(output valid, status, current_state, input ready);
   modport sink(input valid, status, current_state, output ready);
endinterface

// ===== design/dfa_csr_if.sv =====
interface dfa_csr_if;
   logic                            valid;
   logic                            ready;
   logic [dfa_pkg::CSR_IDX_W-1:0]   index;
   logic [dfa_pkg::CSR_DATA_W-1:0]  data;

   modport source(output valid, index, data, input ready);
   modport sink(input valid, index, data, output ready);
endinterface

// ===== design/table_driven_dfa_with_char_classes.sv =====
// A feed word scans k links of the current state (1 <= k <= list length), stopping early
// at an exact match; its result word is loaded once the scan ends, and only after that is the next word taken.
// The scan reads one link a cycle through the single read port of the link memory.
// A feed word that scans nothing, because the machine is dead or the list is empty, goes straight to its result.
// An add or restart word gives a result word; a word with an unknown action gives none.
// Synchronous reset clears the state, dead flag, start and mask registers and every link count's valid flag at once.
module table_driven_dfa_with_char_classes #(
   parameter int NUM_STATES = dfa_pkg::NUM_STATES_DEF,
   parameter int LINKS_PER_STATE = dfa_pkg::LINKS_PER_STATE_DEF
) (
   input  logic        clock,
   input  logic        reset,
   dfa_req_if.sink     req_bus,
   dfa_rsp_if.source   rsp_bus,
   dfa_csr_if.sink     csr_bus
);

   dfa_pkg::dfa_cmd_type  cmd;
   dfa_pkg::dfa_stat_type stat;

   assign csr_bus.ready = 1'b1;

   dfa_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_bus.valid),
      .req_ready (req_bus.ready),
      .rsp_valid (rsp_bus.valid),
      .rsp_ready (rsp_bus.ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   dfa_datapath #(
      .NUM_STATES      (NUM_STATES),
      .LINKS_PER_STATE (LINKS_PER_STATE)
   ) u_datapath (
      .clock             (clock),
      .reset             (reset),
      .req_action        (req_bus.action),
      .req_symbol        (req_bus.symbol),
      .req_link_kind     (req_bus.link_kind),
      .req_from_state    (req_bus.from_state),
      .req_to_state      (req_bus.to_state),
      .csr_we            (csr_bus.valid),
      .csr_index         (csr_bus.index),
      .csr_data          (csr_bus.data),
      .cmd               (cmd),
      .stat              (stat),
      .rsp_status        (rsp_bus.status),
      .rsp_current_state (rsp_bus.current_state)
   );

   // A new result word must never overwrite one that is still waiting.
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      cmd.rsp_load |-> (!rsp_bus.valid || rsp_bus.ready))
      else $error("result word overwritten while pending");

   // An accepted word always starts with a link count lookup.
   a_lookup_follows: assert property (@(posedge clock) disable iff (reset)
      (req_bus.valid && req_bus.ready) |=> cmd.read_count)
      else $error("accepted word not followed by count lookup");

   // Only one phase of the sequencer is active in any cycle.
   a_one_phase: assert property (@(posedge clock) disable iff (reset)
      $onehot0({cmd.load_item, cmd.read_count, cmd.count_step, cmd.scan_step,
                cmd.rsp_load}))
      else $error("overlapping sequencer phases");

   // No word is taken while the previous one is still in progress.
   a_no_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (cmd.read_count || cmd.count_step || cmd.scan_step) |-> !req_bus.ready)
      else $error("input accepted while busy");

endmodule

// ===== design/dfa_ctrl.sv =====
module dfa_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   input  dfa_pkg::dfa_stat_type stat,
   output dfa_pkg::dfa_cmd_type  cmd
);

   typedef enum logic [2:0] {
      S_IDLE,
      S_LOOKUP,
      S_COUNT,
      S_SCAN,
      S_FINISH
   } state_type;

   state_type state_ff;
   logic      rsp_valid_ff;
   logic      rsp_free;
   logic      known_action;

   assign rsp_free = !rsp_valid_ff || rsp_ready;
   assign known_action = (stat.action == dfa_pkg::ACT_FEED) ||
                         (stat.action == dfa_pkg::ACT_ADD) ||
                         (stat.action == dfa_pkg::ACT_RESTART);

   always_comb begin
      cmd = '0;
      cmd.load_item = (state_ff == S_IDLE) && req_valid;
      cmd.read_count = (state_ff == S_LOOKUP);
      cmd.count_step = (state_ff == S_COUNT);
      cmd.scan_step = (state_ff == S_SCAN);
      cmd.scan_final = (state_ff == S_SCAN) && (stat.exact_hit || stat.scan_last);
      cmd.rsp_load = (state_ff == S_FINISH) && rsp_free;
   end

   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (cmd.rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            S_IDLE: begin
               if (req_valid) begin
                  state_ff <= S_LOOKUP;
               end
            end
            S_LOOKUP: begin
               state_ff <= S_COUNT;
            end
            S_COUNT: begin
               if ((stat.action == dfa_pkg::ACT_FEED) && stat.feed_go) begin
                  state_ff <= S_SCAN;
               end else if (known_action) begin
                  state_ff <= S_FINISH;
               end else begin
                  state_ff <= S_IDLE;
               end
            end
            S_SCAN: begin
               if (cmd.scan_final) begin
                  state_ff <= S_FINISH;
               end
            end
            S_FINISH: begin
               if (rsp_free) begin
                  state_ff <= S_IDLE;
               end
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

endmodule

// ===== design/dfa_datapath.sv =====
module dfa_datapath #(
   parameter int NUM_STATES = dfa_pkg::NUM_STATES_DEF,
   parameter int LINKS_PER_STATE = dfa_pkg::LINKS_PER_STATE_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic [dfa_pkg::ACT_W-1:0]       req_action,
   input  logic [dfa_pkg::SYM_W-1:0]       req_symbol,
   input  logic [dfa_pkg::KIND_W-1:0]      req_link_kind,
   input  logic [dfa_pkg::STATE_W-1:0]     req_from_state,
   input  logic [dfa_pkg::STATE_W-1:0]     req_to_state,
   input  logic                            csr_we,
   input  logic [dfa_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [dfa_pkg::CSR_DATA_W-1:0]  csr_data,
   input  dfa_pkg::dfa_cmd_type            cmd,
   output dfa_pkg::dfa_stat_type           stat,
   output logic [dfa_pkg::STATUS_W-1:0]    rsp_status,
   output logic [dfa_pkg::STATE_W-1:0]     rsp_current_state
);

   localparam int SW = (NUM_STATES > 1) ? $clog2(NUM_STATES) : 1;
   localparam int IW = (LINKS_PER_STATE > 1) ? $clog2(LINKS_PER_STATE) : 1;
   localparam int CW = $clog2(LINKS_PER_STATE + 1);
   localparam int DEPTH = NUM_STATES * LINKS_PER_STATE;
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int EW = $bits(dfa_pkg::link_entry_type);
   localparam logic [AW-1:0] LPS_A = AW'(LINKS_PER_STATE);
   localparam logic [CW-1:0] LPS_C = CW'(LINKS_PER_STATE);
   localparam logic [dfa_pkg::STATE_W:0] NS_C = (dfa_pkg::STATE_W + 1)'(NUM_STATES);

   logic [dfa_pkg::STATE_W-1:0]  start_ff;
   logic [dfa_pkg::MASK_W-1:0]   mask_ff;
   logic [dfa_pkg::STATE_W-1:0]  cur_ff;
   logic                         dead_ff;
   logic [NUM_STATES-1:0]        cnt_valid_ff;

   logic [dfa_pkg::ACT_W-1:0]    action_ff;
   logic [dfa_pkg::SYM_W-1:0]    symbol_ff;
   logic [dfa_pkg::KIND_W-1:0]   kind_ff;
   logic [dfa_pkg::STATE_W-1:0]  from_ff;
   logic [dfa_pkg::STATE_W-1:0]  to_ff;

   logic [CW-1:0]                cnt_mem [NUM_STATES];
   logic [CW-1:0]                cnt_rd_ff;
   logic                         cnt_vld_rd_ff;
   logic [EW-1:0]                link_mem [DEPTH];
   logic [EW-1:0]                entry_rd_ff;

   logic [IW-1:0]                k_ff;
   logic                         class_hit_ff;
   logic [dfa_pkg::STATE_W-1:0]  class_to_ff;
   logic                         any_hit_ff;
   logic [dfa_pkg::STATE_W-1:0]  any_to_ff;
   logic [dfa_pkg::STATUS_W-1:0] res_status_ff;
   logic [dfa_pkg::STATE_W-1:0]  res_state_ff;
   logic [dfa_pkg::STATUS_W-1:0] rsp_status_ff;
   logic [dfa_pkg::STATE_W-1:0]  rsp_state_ff;

   logic [dfa_pkg::STATE_W-1:0]  sel_state;
   logic                         sel_ok;
   logic                         from_ok;
   logic                         to_ok;
   logic                         cur_ok;
   logic [CW-1:0]                cnt_val;
   logic                         add_ok;
   logic                         feed_go;
   logic [AW-1:0]                wr_addr;
   logic [IW-1:0]                rd_idx;
   logic [AW-1:0]                rd_addr;
   logic                         rd_en;
   dfa_pkg::link_entry_type      entry;
   logic                         exact;
   logic                         cls;
   logic                         any;
   logic                         class_hit_in;
   logic [dfa_pkg::STATE_W-1:0]  class_to_in;
   logic                         any_hit_in;
   logic [dfa_pkg::STATE_W-1:0]  any_to_in;
   logic                         found;
   logic [dfa_pkg::STATE_W-1:0]  next_state;
   logic                         scan_last;

   assign sel_state = (action_ff == dfa_pkg::ACT_ADD) ? from_ff : cur_ff;
   assign sel_ok = ({1'b0, sel_state} < NS_C);
   assign from_ok = ({1'b0, from_ff} < NS_C);
   assign to_ok = ({1'b0, to_ff} < NS_C);
   assign cur_ok = ({1'b0, cur_ff} < NS_C);
   assign cnt_val = cnt_vld_rd_ff ? cnt_rd_ff : '0;
   assign add_ok = from_ok && to_ok && (cnt_val < LPS_C);
   assign feed_go = !dead_ff && cur_ok && (cnt_val != '0);

   assign wr_addr = AW'(from_ff) * LPS_A + AW'(cnt_val);
   assign rd_idx = cmd.count_step ? '0 : (k_ff + 1'b1);
   assign rd_addr = AW'(cur_ff) * LPS_A + AW'(rd_idx);
   assign rd_en = (cmd.count_step && (action_ff == dfa_pkg::ACT_FEED) && feed_go) ||
                  (cmd.scan_step && !cmd.scan_final);

   assign entry = dfa_pkg::link_entry_type'(entry_rd_ff);
   assign exact = (entry.kind == dfa_pkg::KIND_EXACT) && (entry.label == symbol_ff);
   assign cls = dfa_pkg::class_match(entry.kind, symbol_ff);
   assign any = !cls && (entry.kind == dfa_pkg::KIND_ANY);
   assign class_hit_in = class_hit_ff || cls;
   assign class_to_in = cls ? entry.target : class_to_ff;
   assign any_hit_in = any_hit_ff || any;
   assign any_to_in = any ? entry.target : any_to_ff;
   assign found = exact || class_hit_in || any_hit_in;
   assign next_state = exact ? entry.target :
                       (class_hit_in ? class_to_in : any_to_in);
   assign scan_last = ((CW'(k_ff) + CW'(1)) == cnt_val);

   always_comb begin
      stat = '0;
      stat.action = action_ff;
      stat.feed_go = feed_go;
      stat.exact_hit = exact;
      stat.scan_last = scan_last;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         start_ff <= '0;
         mask_ff <= '0;
         cur_ff <= '0;
         dead_ff <= 1'b0;
         cnt_valid_ff <= '0;
      end else begin
         if (csr_we) begin
            unique case (csr_index)
               dfa_pkg::CSR_START: begin
                  start_ff <= csr_data[dfa_pkg::STATE_W-1:0];
                  cur_ff <= csr_data[dfa_pkg::STATE_W-1:0];
                  dead_ff <= 1'b0;
               end
               dfa_pkg::CSR_MASK: begin
                  mask_ff <= csr_data;
               end
               default: begin
               end
            endcase
         end
         if (cmd.count_step) begin
            case (action_ff)
               dfa_pkg::ACT_ADD: begin
                  if (add_ok) begin
                     cnt_valid_ff[from_ff[SW-1:0]] <= 1'b1;
                  end
               end
               dfa_pkg::ACT_RESTART: begin
                  cur_ff <= start_ff;
                  dead_ff <= 1'b0;
               end
               dfa_pkg::ACT_FEED: begin
                  if (!feed_go) begin
                     dead_ff <= 1'b1;
                  end
               end
               default: begin
               end
            endcase
         end
         if (cmd.scan_final) begin
            if (found) begin
               cur_ff <= next_state;
            end else begin
               dead_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_item) begin
         action_ff <= req_action;
         symbol_ff <= req_symbol;
         kind_ff <= req_link_kind;
         from_ff <= req_from_state;
         to_ff <= req_to_state;
      end
      if (cmd.read_count && sel_ok) begin
         cnt_rd_ff <= cnt_mem[sel_state[SW-1:0]];
         cnt_vld_rd_ff <= cnt_valid_ff[sel_state[SW-1:0]];
      end else if (cmd.read_count) begin
         cnt_vld_rd_ff <= 1'b0;
      end
      if (rd_en) begin
         entry_rd_ff <= link_mem[rd_addr];
      end
      if (cmd.count_step) begin
         k_ff <= '0;
         class_hit_ff <= 1'b0;
         any_hit_ff <= 1'b0;
         case (action_ff)
            dfa_pkg::ACT_ADD: begin
               res_state_ff <= dead_ff ? '0 : cur_ff;
               if (add_ok) begin
                  link_mem[wr_addr] <= {kind_ff, symbol_ff, to_ff};
                  cnt_mem[from_ff[SW-1:0]] <= cnt_val + 1'b1;
                  res_status_ff <= dfa_pkg::ST_ADDED;
               end else begin
                  res_status_ff <= dfa_pkg::ST_FULL;
               end
            end
            dfa_pkg::ACT_RESTART: begin
               res_status_ff <= dfa_pkg::ST_RESTARTED;
               res_state_ff <= start_ff;
            end
            default: begin
               res_status_ff <= dfa_pkg::ST_REJECTED;
               res_state_ff <= '0;
            end
         endcase
      end
      if (cmd.scan_step) begin
         k_ff <= k_ff + 1'b1;
         class_hit_ff <= class_hit_in;
         class_to_ff <= class_to_in;
         any_hit_ff <= any_hit_in;
         any_to_ff <= any_to_in;
      end
      if (cmd.scan_final) begin
         if (found) begin
            res_status_ff <= mask_ff[next_state] ? dfa_pkg::ST_ACCEPTED
                                                 : dfa_pkg::ST_NOT_DONE;
            res_state_ff <= next_state;
         end else begin
            res_status_ff <= dfa_pkg::ST_REJECTED;
            res_state_ff <= '0;
         end
      end
      if (cmd.rsp_load) begin
         rsp_status_ff <= res_status_ff;
         rsp_state_ff <= res_state_ff;
      end
   end

   assign rsp_status = rsp_status_ff;
   assign rsp_current_state = rsp_state_ff;

endmodule
